@@ hdl/mhrs_pkg.sv @@
// ----------------------------------------------------------------------------
// mhrs_pkg
// shared types and constants of the holding register server
// ----------------------------------------------------------------------------
`default_nettype none

package mhrs_pkg;

    localparam int REGISTER_COUNT_DEF = 64;
    localparam int QUEUE_DEPTH        = 2;
    localparam int SENSOR_ADDR_W      = 6;

    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_EXC_FLAG     = 8'h80;
    localparam logic [15:0] READ_LIMIT     = 16'd125;
    localparam logic [8:0] MIN_FRAME       = 9'd8;
    localparam logic [8:0] FULL_FRAME      = 9'd12;

    localparam logic ERR_ILLEGAL_FUNC = 1'b0;
    localparam logic ERR_ILLEGAL_ADDR = 1'b1;

    typedef enum logic [1:0] {
        ITEM_REQUEST  = 2'd0,
        ITEM_SENSOR   = 2'd1,
        ITEM_BUTTON   = 2'd2,
        ITEM_RESERVED = 2'd3
    } t_item;

    typedef enum logic [1:0] {
        RSP_READ  = 2'd0,
        RSP_WRITE = 2'd1,
        RSP_EXC   = 2'd2
    } t_rsp_kind;

    typedef struct packed {
        t_rsp_kind   kind;
        logic [15:0] reply_transaction;
        logic [7:0]  reply_unit;
        logic [7:0]  reply_function;
        logic        error_kind;
        logic [7:0]  byte_count;
        logic [15:0] reg_address;
        logic [15:0] data_word;
        logic        red_led_pin;
        logic        green_led_pin;
        logic        last;
    } t_rsp;

    typedef enum logic [2:0] {
        CMD_REPLY  = 3'd0,
        CMD_WRITE0 = 3'd1,
        CMD_READ   = 3'd2,
        CMD_SENSOR = 3'd3,
        CMD_BUMP   = 3'd4
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                kind;
        t_rsp                     rsp;
        logic [15:0]              arg_lo;
        logic [15:0]              arg_hi;
        logic [SENSOR_ADDR_W-1:0] addr;
        logic                     hi_ok;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE    = 2'd0,
        S_READ    = 2'd1,
        S_SENS_HI = 2'd2,
        S_BUMP_WR = 2'd3
    } t_back_state;

endpackage

`default_nettype wire

@@ hdl/mhrs_if.sv @@
// ----------------------------------------------------------------------------
// mhrs_req_if / mhrs_rsp_if
// request and reply channels, valid/ready with payload
// ----------------------------------------------------------------------------
`default_nettype none

interface mhrs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [8:0]  frame_length;
    logic [15:0] trans_id;
    logic [7:0]  unit_id;
    logic [7:0]  fcode;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic [5:0]  sensor_address;
    logic [31:0] sensor_value;

    modport source (
        output valid, func, frame_length, trans_id, unit_id, fcode,
               first_word, second_word, sensor_address, sensor_value,
        input  ready
    );
    modport sink (
        input  valid, func, frame_length, trans_id, unit_id, fcode,
               first_word, second_word, sensor_address, sensor_value,
        output ready
    );
endinterface

interface mhrs_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] reply_transaction;
    logic [7:0]  reply_unit;
    logic [7:0]  reply_function;
    logic        error_kind;
    logic [7:0]  byte_count;
    logic [15:0] reg_address;
    logic [15:0] data_word;
    logic        red_led_pin;
    logic        green_led_pin;
    logic        last;

    modport source (
        output valid, kind, reply_transaction, reply_unit, reply_function, error_kind,
               byte_count, reg_address, data_word, red_led_pin, green_led_pin, last,
        input  ready
    );
    modport sink (
        input  valid, kind, reply_transaction, reply_unit, reply_function, error_kind,
               byte_count, reg_address, data_word, red_led_pin, green_led_pin, last,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/mhrs_front.sv @@
// ----------------------------------------------------------------------------
// mhrs_front
// accepts request beats, checks frames and ranges, builds commands
// ----------------------------------------------------------------------------
`default_nettype none

module mhrs_front #(
    parameter int REGISTER_COUNT = mhrs_pkg::REGISTER_COUNT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    mhrs_req_if.sink           i_req,
    output mhrs_pkg::t_cmd     o_cmd,
    output logic               o_push,
    input  wire logic          i_full
);
    import mhrs_pkg::*;

    logic        r_phase;
    logic        n_phase;
    logic        accept;
    logic        keep;
    logic        range_bad;
    logic [16:0] read_end;
    logic [6:0]  sensor_next;
    t_cmd        cmd;

    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && i_req.ready;

    assign read_end    = {1'b0, i_req.first_word} + {1'b0, i_req.second_word};
    assign range_bad   = (read_end > 17'(REGISTER_COUNT)) || (i_req.second_word > READ_LIMIT);
    assign sensor_next = {1'b0, i_req.sensor_address} + 7'd1;

    always_comb begin
        cmd                       = '0;
        keep                      = 1'b0;
        cmd.rsp.reply_transaction = i_req.trans_id;
        cmd.rsp.reply_unit        = i_req.unit_id;
        cmd.rsp.reply_function    = i_req.fcode;
        cmd.rsp.last              = 1'b1;
        cmd.addr                  = i_req.sensor_address;
        cmd.arg_lo                = i_req.first_word;
        cmd.arg_hi                = i_req.second_word;
        unique case (t_item'(i_req.func))
            ITEM_REQUEST: begin
                if (i_req.frame_length >= MIN_FRAME) begin
                    if (i_req.fcode == FC_READ_HOLDING) begin
                        if (i_req.frame_length >= FULL_FRAME) begin
                            keep = 1'b1;
                            if (range_bad) begin
                                cmd.kind               = CMD_REPLY;
                                cmd.rsp.kind           = RSP_EXC;
                                cmd.rsp.reply_function = i_req.fcode | FC_EXC_FLAG;
                                cmd.rsp.error_kind     = ERR_ILLEGAL_ADDR;
                            end else if (i_req.second_word == 16'd0) begin
                                cmd.kind     = CMD_REPLY;
                                cmd.rsp.kind = RSP_READ;
                            end else begin
                                cmd.kind           = CMD_READ;
                                cmd.rsp.kind       = RSP_READ;
                                cmd.rsp.byte_count = {i_req.second_word[6:0], 1'b0};
                            end
                        end
                    end else if (i_req.fcode == FC_WRITE_SINGLE) begin
                        if (i_req.frame_length >= FULL_FRAME) begin
                            keep = 1'b1;
                            if (i_req.first_word != 16'd0) begin
                                cmd.kind               = CMD_REPLY;
                                cmd.rsp.kind           = RSP_EXC;
                                cmd.rsp.reply_function = i_req.fcode | FC_EXC_FLAG;
                                cmd.rsp.error_kind     = ERR_ILLEGAL_ADDR;
                            end else begin
                                cmd.kind            = CMD_WRITE0;
                                cmd.rsp.kind        = RSP_WRITE;
                                cmd.rsp.reg_address = i_req.first_word;
                                cmd.rsp.data_word   = i_req.second_word;
                                cmd.arg_lo          = i_req.second_word;
                            end
                        end
                    end else begin
                        keep                   = 1'b1;
                        cmd.kind               = CMD_REPLY;
                        cmd.rsp.kind           = RSP_EXC;
                        cmd.rsp.reply_function = i_req.fcode | FC_EXC_FLAG;
                        cmd.rsp.error_kind     = ERR_ILLEGAL_FUNC;
                    end
                end
            end
            ITEM_SENSOR: begin
                keep       = ({1'b0, i_req.sensor_address} < 7'(REGISTER_COUNT));
                cmd.kind   = CMD_SENSOR;
                cmd.arg_lo = i_req.sensor_value[15:0];
                cmd.arg_hi = i_req.sensor_value[31:16];
                cmd.hi_ok  = (sensor_next < 7'(REGISTER_COUNT));
            end
            ITEM_BUTTON: begin
                // counter moves on every other button beat
                keep     = !r_phase;
                cmd.kind = CMD_BUMP;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign n_phase = (accept && (t_item'(i_req.func) == ITEM_BUTTON)) ? !r_phase : r_phase;
    assign o_push  = accept && keep;
    assign o_cmd   = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

@@ hdl/mhrs_queue.sv @@
// ----------------------------------------------------------------------------
// mhrs_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module mhrs_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  mhrs_pkg::t_cmd      i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output mhrs_pkg::t_cmd      o_cmd,
    output logic                o_empty
);
    import mhrs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/mhrs_back.sv @@
// ----------------------------------------------------------------------------
// mhrs_back
// register file and command execution, streams read beats
// ----------------------------------------------------------------------------
`default_nettype none

module mhrs_back #(
    parameter int REGISTER_COUNT = mhrs_pkg::REGISTER_COUNT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  mhrs_pkg::t_cmd     i_cmd,
    input  wire logic          i_empty,
    output logic               o_pop,
    output mhrs_pkg::t_rsp     o_rsp,
    output logic               o_valid,
    input  wire logic          i_ready
);
    import mhrs_pkg::*;

    localparam int AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam int CW = $clog2(REGISTER_COUNT + 1);

    t_back_state         r_state;
    t_back_state         n_state;

    logic [15:0]         r_mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] r_valid;
    logic [15:0]         r_rd_word;
    logic                r_rd_ok;
    logic [15:0]         r_reg0;
    logic [15:0]         n_reg0;

    logic [AW-1:0]       r_addr;
    logic [CW-1:0]       r_rem;
    logic [15:0]         r_hi;
    t_rsp                r_hdr;
    logic                r_q_full;
    logic                r_q_last;
    t_rsp                r_out;
    t_rsp                n_out;
    logic                r_out_valid;

    logic                out_free;
    logic                move;
    logic                head_go;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [15:0]         wdata;
    logic                re;
    logic [AW-1:0]       raddr;
    logic                load_cmd;
    logic                start_rd;
    logic                issue;
    logic [15:0]         rd_value;

    assign out_free = !r_out_valid || i_ready;
    assign move     = r_q_full && out_free;
    assign head_go  = !i_empty && !r_q_full;
    assign rd_value = r_rd_ok ? r_rd_word : 16'd0;
    assign n_reg0   = (we && (waddr == '0)) ? wdata : r_reg0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (head_go) begin
                    case (i_cmd.kind)
                        CMD_READ:   n_state = S_READ;
                        CMD_SENSOR: n_state = i_cmd.hi_ok ? S_SENS_HI : S_IDLE;
                        CMD_BUMP:   n_state = S_BUMP_WR;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: begin
                if (r_rem == '0) begin
                    n_state = S_IDLE;
                end
            end
            S_SENS_HI: n_state = S_IDLE;
            S_BUMP_WR: n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop    = 1'b0;
        we       = 1'b0;
        waddr    = '0;
        wdata    = '0;
        re       = 1'b0;
        raddr    = '0;
        load_cmd = 1'b0;
        start_rd = 1'b0;
        issue    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (head_go) begin
                    unique case (i_cmd.kind)
                        CMD_REPLY: begin
                            if (out_free) begin
                                o_pop    = 1'b1;
                                load_cmd = 1'b1;
                            end
                        end
                        CMD_WRITE0: begin
                            if (out_free) begin
                                o_pop    = 1'b1;
                                load_cmd = 1'b1;
                                we       = 1'b1;
                                wdata    = i_cmd.arg_lo;
                            end
                        end
                        CMD_READ: begin
                            o_pop    = 1'b1;
                            start_rd = 1'b1;
                        end
                        CMD_SENSOR: begin
                            o_pop = 1'b1;
                            we    = 1'b1;
                            waddr = i_cmd.addr[AW-1:0];
                            wdata = i_cmd.arg_lo;
                        end
                        CMD_BUMP: begin
                            o_pop = 1'b1;
                            re    = 1'b1;
                            raddr = AW'(1);
                        end
                        default: begin
                            o_pop = 1'b0;
                        end
                    endcase
                end
            end
            S_READ: begin
                if ((r_rem != '0) && (!r_q_full || move)) begin
                    re    = 1'b1;
                    raddr = r_addr;
                    issue = 1'b1;
                end
            end
            S_SENS_HI: begin
                we    = 1'b1;
                waddr = r_addr;
                wdata = r_hi;
            end
            S_BUMP_WR: begin
                we    = 1'b1;
                waddr = AW'(1);
                wdata = rd_value + 16'd1;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // output register source
    always_comb begin
        n_out = r_out;
        if (move) begin
            n_out           = r_hdr;
            n_out.data_word = rd_value;
            n_out.last      = r_q_last;
        end else if (load_cmd) begin
            n_out = i_cmd.rsp;
        end
        if (move || load_cmd) begin
            n_out.red_led_pin   = !n_reg0[0];
            n_out.green_led_pin = !n_reg0[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_rd_word <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_rd) begin
            r_addr <= i_cmd.arg_lo[AW-1:0];
            r_hdr  <= i_cmd.rsp;
        end else if (issue) begin
            r_addr <= r_addr + AW'(1);
        end else if ((r_state == S_IDLE) && head_go && (i_cmd.kind == CMD_SENSOR)) begin
            r_addr <= i_cmd.addr[AW-1:0] + AW'(1);
            r_hi   <= i_cmd.arg_hi;
        end
        if (issue) begin
            r_q_last <= (r_rem == CW'(1));
        end
        if (move || load_cmd) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_rd_ok     <= 1'b0;
            r_reg0      <= '0;
            r_rem       <= '0;
            r_q_full    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
            if (re) begin
                r_rd_ok <= r_valid[raddr];
            end
            r_reg0 <= n_reg0;
            if (start_rd) begin
                r_rem <= i_cmd.arg_hi[CW-1:0];
            end else if (issue) begin
                r_rem <= r_rem - CW'(1);
            end
            r_q_full <= issue || (r_q_full && !move);
            if (move || load_cmd) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp   = r_out;
    assign o_valid = r_out_valid;

    // a waiting read word is never overwritten
    a_q_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_full && !out_free) |=> (r_q_full && $stable(rd_value)))
        else $error("read word dropped while output stalled");

    // the last beat of a stream leaves nothing outstanding
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_q_last) |-> (r_rem == '0))
        else $error("last beat with words still outstanding");

    // led shadow tracks writes to register 0
    a_reg0_shadow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && (waddr == '0)) |=> (r_reg0 == $past(wdata)))
        else $error("register 0 shadow out of step");

    // idle replies never collide with a streaming beat
    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(move && load_cmd))
        else $error("two sources load the output register");

endmodule

`default_nettype wire

@@ hdl/modbus_holding_register_server.sv @@
// ----------------------------------------------------------------------------
// modbus_holding_register_server
// holding register server: read holding registers, write single register
// ----------------------------------------------------------------------------
// path: command queue, output register; read beats pass r_addr and r_rd_word in between
// throughput: a read of N registers streams N beats at one per cycle while the reply
//   channel is ready, bound by the single read port of the register file
// write, exception and empty read replies take one beat; sensor stores write the low
//   word, then the high word if in range; button bumps read then write register 1
// reset: synchronous, active low; per-entry valid bits clear the register file at once
`default_nettype none

module modbus_holding_register_server #(
    parameter int REGISTER_COUNT = mhrs_pkg::REGISTER_COUNT_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mhrs_req_if.sink    i_req,
    mhrs_rsp_if.source  o_rsp
);
    import mhrs_pkg::*;

    // front to queue
    t_cmd front_cmd;
    logic front_push;
    logic queue_full;

    // queue to back
    t_cmd queue_cmd;
    logic queue_empty;
    logic back_pop;

    // back to reply channel
    t_rsp back_rsp;
    logic back_valid;

    // front: classifies every beat; drops short frames, reserved items, sensor
    // items out of range, every other button; folds range checks into replies
    mhrs_front #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_cmd   (front_cmd),
        .o_push  (front_push),
        .i_full  (queue_full)
    );

    // queue: lets the front keep accepting while a read streams out
    mhrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_cmd   (queue_cmd),
        .o_empty (queue_empty)
    );

    // back: register file, writes, and the reply output register
    mhrs_back #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (queue_cmd),
        .i_empty (queue_empty),
        .o_pop   (back_pop),
        .o_rsp   (back_rsp),
        .o_valid (back_valid),
        .i_ready (o_rsp.ready)
    );

    // reply channel, straight from the output register
    assign o_rsp.valid             = back_valid;
    assign o_rsp.kind              = back_rsp.kind;
    assign o_rsp.reply_transaction = back_rsp.reply_transaction;
    assign o_rsp.reply_unit        = back_rsp.reply_unit;
    assign o_rsp.reply_function    = back_rsp.reply_function;
    assign o_rsp.error_kind        = back_rsp.error_kind;
    assign o_rsp.byte_count        = back_rsp.byte_count;
    assign o_rsp.reg_address       = back_rsp.reg_address;
    assign o_rsp.data_word         = back_rsp.data_word;
    assign o_rsp.red_led_pin       = back_rsp.red_led_pin;
    assign o_rsp.green_led_pin     = back_rsp.green_led_pin;
    assign o_rsp.last              = back_rsp.last;

endmodule

`default_nettype wire
